@@ rtl/csvft_pkg.sv @@
// ----------------------------------------------------------------------------
// csvft_pkg
// Shared constants and types for the csv field tokenizer.
// ----------------------------------------------------------------------------
package csvft_pkg;

    localparam int DEF_MAX_FIELDS    = 64;
    localparam int DEF_MAX_SPACE_RUN = 255;

    localparam int CHAR_W      = 8;
    localparam int RUN_W       = 8;
    localparam int FIELD_IDX_W = 6;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic                   has_char;
        logic [CHAR_W-1:0]      out_char;
        logic [RUN_W-1:0]       space_run;
        logic [FIELD_IDX_W-1:0] field_index;
        logic                   field_done;
        logic                   line_done;
    } t_result;

endpackage

@@ rtl/csvft_in_if.sv @@
// ----------------------------------------------------------------------------
// csvft_in_if
// Character channel: one line character or end-of-line mark per item.
// ----------------------------------------------------------------------------
interface csvft_in_if;
    import csvft_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              end_mark;

    modport source (output valid, output ch, output end_mark, input ready);
    modport sink (input valid, input ch, input end_mark, output ready);

endinterface

@@ rtl/csvft_out_if.sv @@
// ----------------------------------------------------------------------------
// csvft_out_if
// Token channel: field characters and field / line boundaries.
// ----------------------------------------------------------------------------
interface csvft_out_if;
    import csvft_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   has_char;
    logic [CHAR_W-1:0]      out_char;
    logic [RUN_W-1:0]       space_run;
    logic [FIELD_IDX_W-1:0] field_index;
    logic                   field_done;
    logic                   line_done;

    modport source (
        output valid, output has_char, output out_char, output space_run,
        output field_index, output field_done, output line_done,
        input ready
    );
    modport sink (
        input valid, input has_char, input out_char, input space_run,
        input field_index, input field_done, input line_done,
        output ready
    );

endinterface

@@ rtl/csvft_parse.sv @@
// ----------------------------------------------------------------------------
// csvft_parse
// Parser state machine: field mode, field counter and pending space count,
// with the next-state and result logic for one character.
// ----------------------------------------------------------------------------
module csvft_parse #(
    parameter int MAX_FIELDS    = csvft_pkg::DEF_MAX_FIELDS,
    parameter int MAX_SPACE_RUN = csvft_pkg::DEF_MAX_SPACE_RUN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [csvft_pkg::CHAR_W-1:0] i_ch,
    input  logic                         i_end_mark,
    output logic                         o_res_valid,
    output csvft_pkg::t_result           o_res
);
    import csvft_pkg::*;

    localparam int FC_W = $clog2(MAX_FIELDS);
    localparam int PS_W = $clog2(MAX_SPACE_RUN + 1);

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_PLAIN  = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_QSEEN  = 3'd3;
    localparam logic [2:0] MODE_TAIL   = 3'd4;

    localparam logic [FC_W-1:0] FC_LAST = FC_W'(MAX_FIELDS - 1);
    localparam logic [PS_W-1:0] PS_MAX  = PS_W'(MAX_SPACE_RUN);

    logic [2:0]      r_mode, n_mode;
    logic [FC_W-1:0] r_fc, n_fc;
    logic [PS_W-1:0] r_ps, n_ps;

    logic    emit;
    logic    close_fld;
    t_result res;

    always_comb begin
        n_mode    = r_mode;
        n_fc      = r_fc;
        n_ps      = r_ps;
        emit      = 1'b0;
        close_fld = 1'b0;
        res       = '0;
        res.field_index = FIELD_IDX_W'(r_fc);

        if (i_end_mark) begin
            emit           = 1'b1;
            res.field_done = 1'b1;
            res.line_done  = 1'b1;
            n_mode         = MODE_START;
            n_fc           = '0;
            n_ps           = '0;
        end else begin
            unique case (r_mode)
                MODE_PLAIN: begin
                    if (i_ch == CH_COMMA) begin
                        close_fld = 1'b1;
                    end else if (i_ch == CH_SPACE) begin
                        if (r_ps < PS_MAX) begin
                            n_ps = r_ps + 1'b1;
                        end
                    end else begin
                        emit          = 1'b1;
                        res.has_char  = 1'b1;
                        res.out_char  = i_ch;
                        res.space_run = RUN_W'(r_ps);
                        n_ps          = '0;
                    end
                end
                MODE_QUOTED: begin
                    if (i_ch == CH_QUOTE) begin
                        n_mode = MODE_QSEEN;
                    end else begin
                        emit         = 1'b1;
                        res.has_char = 1'b1;
                        res.out_char = i_ch;
                    end
                end
                MODE_QSEEN: begin
                    // doubled quote gives one quote character
                    if (i_ch == CH_QUOTE) begin
                        n_mode       = MODE_QUOTED;
                        emit         = 1'b1;
                        res.has_char = 1'b1;
                        res.out_char = CH_QUOTE;
                    end else if (i_ch == CH_COMMA) begin
                        close_fld = 1'b1;
                    end else begin
                        n_mode = MODE_TAIL;
                    end
                end
                MODE_TAIL: begin
                    if (i_ch == CH_COMMA) begin
                        close_fld = 1'b1;
                    end
                end
                default: begin
                    // field start, unused codes behave the same
                    if (i_ch == CH_COMMA) begin
                        close_fld = 1'b1;
                    end else if (i_ch == CH_QUOTE) begin
                        n_mode = MODE_QUOTED;
                    end else if (i_ch != CH_SPACE) begin
                        n_mode       = MODE_PLAIN;
                        n_ps         = '0;
                        emit         = 1'b1;
                        res.has_char = 1'b1;
                        res.out_char = i_ch;
                    end
                end
            endcase

            if (close_fld) begin
                emit           = 1'b1;
                res.field_done = 1'b1;
                n_mode         = MODE_START;
                n_ps           = '0;
                if (r_fc < FC_LAST) begin
                    n_fc = r_fc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_fc   <= '0;
            r_ps   <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_fc   <= n_fc;
            r_ps   <= n_ps;
        end
    end

    assign o_res_valid = emit;
    assign o_res       = res;

endmodule

@@ rtl/csv_field_tokenizer.sv @@
// a result passes through the character register and then the result register
// after its character is accepted, and is held there until it is taken
// throughput: 1 character per cycle unless the output stalls, set by the input and result registers
// characters that are skipped or held back give no result item
// reset: synchronous active low, parser returns to field start with field
// counter and pending space count at zero, both pipeline registers empty
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a character stream into comma-separated fields with quote handling
// and trailing-space removal.
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
    parameter int MAX_FIELDS    = csvft_pkg::DEF_MAX_FIELDS,
    parameter int MAX_SPACE_RUN = csvft_pkg::DEF_MAX_SPACE_RUN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csvft_in_if.sink    i_in,
    csvft_out_if.source o_out
);
    import csvft_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_ch;
    logic              r_end_mark;
    logic              r_out_valid;
    t_result           r_out;

    logic    step;
    logic    in_ready;
    logic    res_valid;
    t_result res;

    // the character register advances whenever the result register is free
    assign step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || step;

    csvft_parse #(
        .MAX_FIELDS    (MAX_FIELDS),
        .MAX_SPACE_RUN (MAX_SPACE_RUN)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (r_ch),
        .i_end_mark  (r_end_mark),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_ch       <= i_in.ch;
            r_end_mark <= i_in.end_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.has_char    = r_out.has_char;
    assign o_out.out_char    = r_out.out_char;
    assign o_out.space_run   = r_out.space_run;
    assign o_out.field_index = r_out.field_index;
    assign o_out.field_done  = r_out.field_done;
    assign o_out.line_done   = r_out.line_done;

endmodule
